// ===== design/bts_pkg.sv =====
// Shared constants and types for the binary thinning sub-pass unit.
package bts_pkg;

   localparam int DEF_MAX_WIDTH = 1024;

   localparam int FW_W       = 11;  // frame_width register
   localparam int FH_W       = 12;  // frame_height register
   localparam int ROW_W      = 13;  // input row counter runs past the frame during drain
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int MIN_DIM      = 3;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // Output queue
   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int OCC_W      = FIFO_CNT_W + 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_METHOD       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_PASS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd3;

   localparam logic METHOD_ZHANG_SUEN = 1'b0;
   localparam logic METHOD_GUO_HALL   = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // Per-beat control handed from the sequencer to the decision stage
   typedef struct packed {
      logic pix;
      logic emit;
      logic last;
      logic interior;
   } bts_item_type;

   typedef struct packed {
      logic out_pixel;
      logic removed;
      logic last;
      logic any_removed;
   } bts_result_type;

endpackage

// ===== design/bts_line_store.sv =====
// Two-row line store: one synchronous 2-bit memory with same-address forwarding.
module bts_line_store
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int CW        = $clog2(MAX_WIDTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [CW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [CW-1:0] wr_addr,
   input  logic [1:0]    wr_data,   // {row above, current row}
   output logic [1:0]    rd_data    // {two rows above, row above}
);

   logic [1:0] mem [MAX_WIDTH];
   logic [1:0] mem_q_ff;
   logic [1:0] fwd_data_ff;
   logic       fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // write and read of one entry at the same edge: take the new data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : mem_q_ff;

endmodule

// ===== design/bts_seq.sv =====
// Raster sequencer: input/output position counters, line store read, stage-1 control.
module bts_seq
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int CW        = $clog2(MAX_WIDTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            cmd,
   input  logic            pixel,
   input  logic [FW_W-1:0] frame_width,
   input  logic [FH_W-1:0] frame_height,
   output logic            rd_en,
   output logic [CW-1:0]   rd_addr,
   output logic            s1_valid_ff,
   output bts_item_type    item_ff,
   output logic [CW-1:0]   addr_ff
);

   localparam int WW = $clog2(MAX_WIDTH + 1);

   logic [CW-1:0]    in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [CW-1:0]    out_col_ff, out_col_in;
   logic [FH_W-1:0]  out_row_ff, out_row_in;
   logic             s1_valid_in;
   bts_item_type     item_in;

   logic [WW-1:0]    w_eff;
   logic [FH_W-1:0]  h_eff;
   logic             drain;
   logic             ignore;
   logic [WW-1:0]    col_inc;
   logic [WW-1:0]    out_col_inc;
   logic [ROW_W-1:0] out_row_inc;
   logic             col_wrap;
   logic             out_col_wrap;

   always_comb begin
      if (frame_width < FW_W'(MIN_DIM)) begin
         w_eff = WW'(MIN_DIM);
      end else if (32'(frame_width) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(frame_width);
      end
      h_eff = (frame_height < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height;

      drain  = in_row_ff >= ROW_W'(h_eff);
      // flush inside the frame is dropped; after the frame every beat drains
      ignore = !drain && (cmd == CMD_FLUSH);

      col_inc      = WW'(in_col_ff) + WW'(1);
      col_wrap     = col_inc >= w_eff;
      out_col_inc  = WW'(out_col_ff) + WW'(1);
      out_col_wrap = out_col_inc >= w_eff;
      out_row_inc  = ROW_W'(out_row_ff) + ROW_W'(1);

      item_in.pix      = drain ? 1'b0 : pixel;
      item_in.emit     = (in_row_ff >= ROW_W'(2)) ||
                         ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      item_in.last     = (out_row_inc >= ROW_W'(h_eff)) && out_col_wrap;
      item_in.interior = (out_row_ff != '0) && (out_row_inc < ROW_W'(h_eff)) &&
                         (out_col_ff != '0) && (out_col_inc < w_eff);

      s1_valid_in = accept && !ignore;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (s1_valid_in) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = col_inc[CW-1:0];
         end
         if (item_in.emit) begin
            if (item_in.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_inc[FH_W-1:0];
            end else begin
               out_col_in = out_col_inc[CW-1:0];
            end
         end
      end
   end

   assign rd_en   = s1_valid_in;
   assign rd_addr = in_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         item_ff <= item_in;
         addr_ff <= in_col_ff;
      end
   end

   a_s1_from_accept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(accept))
      else $error("stage 1 holds a beat that was never accepted");

   a_last_is_emit: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && item_ff.last) |-> item_ff.emit)
      else $error("frame end flagged on a beat without a result");

endmodule

// ===== design/bts_decide.sv =====
// 3x3 window, Zhang-Suen / Guo-Hall deletion tests and frame removal flag.
module bts_decide
   import bts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           s1_valid,
   input  bts_item_type   item,
   input  logic [1:0]     rd_data,   // {two rows above, row above}
   input  logic           method,
   input  logic           sub_pass,
   output logic           push,
   output bts_result_type result
);

   // p[7:0] = {p9, p8, p7, p6, p5, p4, p3, p2}
   function automatic logic [7:0] ring(input logic [8:0] w);
      ring = {w[0], w[1], w[2], w[5], w[8], w[7], w[6], w[3]};
   endfunction

   function automatic logic zs_test(input logic [8:0] w, input logic odd);
      logic [7:0] p;
      logic [7:0] rise;
      logic [3:0] a;
      logic [3:0] b;
      logic       m1;
      logic       m2;
      p    = ring(w);
      rise = ~p & {p[0], p[7:1]};
      a    = '0;
      b    = '0;
      for (int k = 0; k < 8; k++) begin
         a = a + 4'(rise[k]);
         b = b + 4'(p[k]);
      end
      if (!odd) begin
         m1 = p[0] & p[2] & p[4];
         m2 = p[2] & p[4] & p[6];
      end else begin
         m1 = p[0] & p[2] & p[6];
         m2 = p[0] & p[4] & p[6];
      end
      zs_test = (a == 4'd1) && (b >= 4'd2) && (b <= 4'd6) && !m1 && !m2;
   endfunction

   function automatic logic gh_test(input logic [8:0] w, input logic odd);
      logic [7:0] p;
      logic [2:0] c;
      logic [2:0] n1;
      logic [2:0] n2;
      logic [2:0] n;
      logic       m;
      p  = ring(w);
      c  = 3'(~p[0] & (p[1] | p[2])) + 3'(~p[2] & (p[3] | p[4])) +
           3'(~p[4] & (p[5] | p[6])) + 3'(~p[6] & (p[7] | p[0]));
      n1 = 3'(p[7] | p[0]) + 3'(p[1] | p[2]) + 3'(p[3] | p[4]) + 3'(p[5] | p[6]);
      n2 = 3'(p[0] | p[1]) + 3'(p[2] | p[3]) + 3'(p[4] | p[5]) + 3'(p[6] | p[7]);
      n  = (n1 < n2) ? n1 : n2;
      if (!odd) begin
         m = (p[4] | p[5] | ~p[7]) & p[6];
      end else begin
         m = (p[0] | p[1] | ~p[3]) & p[2];
      end
      gh_test = (c == 3'd1) && (n >= 3'd2) && (n <= 3'd3) && !m;
   endfunction

   logic [8:0] window_ff, window_in;
   logic       removed_seen_ff, removed_seen_in;
   logic       center;
   logic       pass;
   logic       rem;

   always_comb begin
      window_in = {item.pix, rd_data[0], rd_data[1], window_ff[8:3]};
      center    = window_in[4];
      pass      = (method == METHOD_GUO_HALL) ? gh_test(window_in, sub_pass)
                                              : zs_test(window_in, sub_pass);
      rem       = item.interior & center & pass;

      push                = s1_valid && item.emit;
      result.out_pixel    = center & ~rem;
      result.removed      = rem;
      result.last         = item.last;
      result.any_removed  = item.last & (removed_seen_ff | rem);

      removed_seen_in = removed_seen_ff;
      if (push) begin
         removed_seen_in = item.last ? 1'b0 : (removed_seen_ff | rem);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff       <= '0;
         removed_seen_ff <= 1'b0;
      end else begin
         if (s1_valid) begin
            window_ff <= window_in;
         end
         removed_seen_ff <= removed_seen_in;
      end
   end

   a_any_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (push && result.any_removed) |-> result.last)
      else $error("frame removal flag outside the last beat");

   a_seen_cleared: assert property (@(posedge clock) disable iff (reset)
      (push && result.last) |=> !removed_seen_ff)
      else $error("removal flag survived the frame end");

endmodule

// ===== design/bts_out_fifo.sv =====
// Small result queue between the decision stage and the response port.
module bts_out_fifo
   import bts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bts_result_type        push_data,
   input  logic                  pop,
   output logic                  out_valid,
   output bts_result_type        out_data,
   output logic [FIFO_CNT_W-1:0] count
);

   bts_result_type         entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;

   function automatic logic [FIFO_PTR_W-1:0] bump(input logic [FIFO_PTR_W-1:0] p);
      bump = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff != FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("result queue overflow");

endmodule

// ===== design/binary_thinning_subpass_unit.sv =====
// Top level of the binary thinning sub-pass unit.
//
// Usage:
//  - req_ channel: one beat per pixel in raster order (req_cmd = pixel) or a
//    flush tick (req_cmd = flush). Flush beats inside a frame are dropped;
//    after the last pixel of the frame, frame_width + 1 beats of any kind
//    drain the tail.
//  - rsp_ channel: one beat per pixel of the frame, lagging the input by
//    frame_width + 1 beats. rsp_last marks the final pixel, and on it
//    rsp_any_removed tells whether this sub-pass deleted anything.
//  - csr_ channel: register writes (method, sub_pass, frame_width,
//    frame_height); write only while the unit is idle.
//  - Result path: the input beat completing a window is accepted with the
//    line store read registered, then the decision stage pushes the result
//    into the output queue, whose head is presented on rsp_.
//  - Throughput: one beat per cycle while req_ready is high. The line store
//    memory is read in the accept cycle and written back the next; a
//    same-column overlap is forwarded inside the line store.
//  - Reset: counters, window, flags and registers go to their defaults. The
//    line store is not cleared; its first-row contents only feed border
//    pixels, which pass through.
//  - Stall: a 3-entry output queue absorbs results; req_ready drops when the
//    queue plus the beat in flight would fill it.
module binary_thinning_subpass_unit
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic                  req_pixel,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_out_pixel,
   output logic                  rsp_removed,
   output logic                  rsp_last,
   output logic                  rsp_any_removed,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);

   // configuration registers
   logic            method_ff;
   logic            sub_pass_ff;
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;

   logic                  accept;
   logic                  rd_en;
   logic [CW-1:0]         rd_addr;
   logic [1:0]            rd_data;
   logic                  s1_valid;
   bts_item_type          s1_item;
   logic [CW-1:0]         s1_addr;
   logic                  push;
   bts_result_type        result;
   bts_result_type        head;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [OCC_W-1:0]      occupancy;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff       <= METHOD_ZHANG_SUEN;
         sub_pass_ff     <= 1'b0;
         frame_width_ff  <= FW_W'(RESET_WIDTH);
         frame_height_ff <= FH_W'(RESET_HEIGHT);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_METHOD:       method_ff       <= csr_data[0];
            CSR_SUB_PASS:     sub_pass_ff     <= csr_data[0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            default:          method_ff       <= method_ff;
         endcase
      end
   end

   // Queue entries plus a result still in the decision stage must leave a slot.
   assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_valid && s1_item.emit);
   assign req_ready = !reset && (occupancy < OCC_W'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;

   bts_seq #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req_cmd),
      .pixel        (req_pixel),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .s1_valid_ff  (s1_valid),
      .item_ff      (s1_item),
      .addr_ff      (s1_addr)
   );

   // Write back shifts the column down one row: row above -> two above,
   // new pixel -> row above.
   bts_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (s1_valid),
      .wr_addr (s1_addr),
      .wr_data ({rd_data[0], s1_item.pix}),
      .rd_data (rd_data)
   );

   bts_decide u_decide (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .item     (s1_item),
      .rd_data  (rd_data),
      .method   (method_ff),
      .sub_pass (sub_pass_ff),
      .push     (push),
      .result   (result)
   );

   bts_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop       (rsp_valid && rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (head),
      .count     (fifo_count)
   );

   assign rsp_out_pixel   = head.out_pixel;
   assign rsp_removed     = head.removed;
   assign rsp_last        = head.last;
   assign rsp_any_removed = head.any_removed;

endmodule
